@@ hw/rtl/ts2ep_pkg.sv @@
`default_nettype none

package ts2ep_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_W       = 57;
    localparam int OUT_TDATA_W = 64;
    localparam int POS_W       = 5;
    localparam int YEAR_W      = 14;
    localparam int FLD_W       = 7;
    localparam int FRAC_W      = 10;
    localparam int YOFF_W      = 11;
    localparam int Q_W         = 4;
    localparam int MOFF_W      = 9;
    localparam int DAYS_W      = 19;
    localparam int HMS_W       = 17;
    localparam int SECS_W      = 35;
    localparam int MS_W        = 45;
    localparam int SEC_DIG_W   = 37;

    localparam logic [POS_W-1:0] POS_MAX       = 5'd31;
    localparam logic [POS_W-1:0] ISO_LEN       = 5'd19;
    localparam logic [POS_W-1:0] MS_DIGITS_MAX = 5'd17;
    localparam logic [POS_W-1:0] POS_DASH_Y    = 5'd4;
    localparam logic [POS_W-1:0] POS_DASH_M    = 5'd7;
    localparam logic [POS_W-1:0] POS_SEP_T     = 5'd10;
    localparam logic [POS_W-1:0] POS_COLON_H   = 5'd13;
    localparam logic [POS_W-1:0] POS_COLON_M   = 5'd16;

    localparam logic [IN_TDATA_W-1:0] CH_ZERO  = 16'd48;
    localparam logic [IN_TDATA_W-1:0] CH_NINE  = 16'd57;
    localparam logic [IN_TDATA_W-1:0] CH_DASH  = 16'd45;
    localparam logic [IN_TDATA_W-1:0] CH_T     = 16'd84;
    localparam logic [IN_TDATA_W-1:0] CH_SPACE = 16'd32;
    localparam logic [IN_TDATA_W-1:0] CH_COLON = 16'd58;
    localparam logic [IN_TDATA_W-1:0] CH_DOT   = 16'd46;

    localparam logic [YEAR_W-1:0] YEAR_MIN   = 14'd1970;
    localparam logic [YEAR_W-1:0] YEAR_MAX   = 14'd3000;
    localparam logic [YEAR_W-1:0] YEAR_BASE  = 14'd1600;
    localparam logic [DAYS_W-1:0] DAY_BIAS   = 19'd135081;
    localparam logic [SECS_W-1:0] SECS_LIMIT = 35'd32535215999;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic              digits;
        logic [OUT_W-1:0]  acc;
        logic              iso_ok;
        logic [YEAR_W-1:0] year;
        logic [FLD_W-1:0]  mon;
        logic [FLD_W-1:0]  day;
        logic [FLD_W-1:0]  hour;
        logic [FLD_W-1:0]  minute;
        logic [FLD_W-1:0]  sec;
        logic [FRAC_W-1:0] frac;
        logic [1:0]        fcnt;
        logic              fopen;
    } t_str;

    localparam t_str STR_RESET = '{
        pos: '0, digits: 1'b1, acc: '0, iso_ok: 1'b1, year: '0, mon: '0, day: '0,
        hour: '0, minute: '0, sec: '0, frac: '0, fcnt: '0, fopen: 1'b0
    };

    // days from 1 March to the first of the month
    function automatic logic [MOFF_W-1:0] month_offset(input logic [3:0] mon);
        logic [MOFF_W-1:0] r;
        case (mon)
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/timestamp_text_to_epoch_ms_top.sv @@
// Timestamp text to Unix epoch milliseconds, one character per cycle unless stalled.
// Throughput: one character per cycle unless stalled, set by the accumulator update.
// Five-stage conversion pipeline (snapshot, checks, day count, seconds, milliseconds).
// Reset (i_rst_n low, synchronous) clears the string state and empties the pipeline.
`default_nettype none

module timestamp_text_to_epoch_ms_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [ts2ep_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // [15:0] char_code
    input  logic                               i_s_axis_tuser,  // [0] has_char
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [ts2ep_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata   // [56:0] epoch_ms
);
    import ts2ep_pkg::*;

    t_str r_str, n_str;
    logic w_in_acc, w_res, w_dig;
    logic [3:0] w_dv;
    logic [IN_TDATA_W-1:0] w_c;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    // stage 1
    t_str r1_str;
    logic r1_zero;
    // stage 2
    logic              r2_dmode, r2_bad;
    logic [OUT_W-1:0]  r2_dval;
    logic [FRAC_W-1:0] r2_fms;
    logic [YOFF_W-1:0] r2_t;
    logic [Q_W-1:0]    r2_q;
    logic [MOFF_W-1:0] r2_moff;
    logic [FLD_W-1:0]  r2_day, r2_hour, r2_min, r2_sec;
    // stage 3
    logic              r3_dmode, r3_bad;
    logic [OUT_W-1:0]  r3_dval;
    logic [FRAC_W-1:0] r3_fms;
    logic [DAYS_W-1:0] r3_days;
    logic [HMS_W-1:0]  r3_hms;
    // stage 4
    logic              r4_dmode, r4_bad;
    logic [OUT_W-1:0]  r4_dval;
    logic [FRAC_W-1:0] r4_fms;
    logic [SECS_W-1:0] r4_secs;
    // stage 5
    logic [OUT_W-1:0]  r5_ms;

    logic              w2_dmode, w2_bad;
    logic [OUT_W-1:0]  w2_dval;
    logic [FRAC_W-1:0] w2_fms;
    logic [YEAR_W-1:0] w2_yy;
    logic [YOFF_W-1:0] w2_t;
    logic [Q_W-1:0]    w2_q;
    logic [DAYS_W-1:0] w3_days;
    logic [HMS_W-1:0]  w3_hms;
    logic [SECS_W-1:0] w4_secs;
    logic [MS_W-1:0]   w5_ms;
    logic [OUT_W-1:0]  w5_out;

    assign w_rdy5 = !r_v5 || i_m_axis_tready;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign o_s_axis_tready = w_rdy1;
    assign w_in_acc        = i_s_axis_tvalid && w_rdy1;
    assign w_res           = !i_s_axis_tuser || i_s_axis_tlast;

    assign w_c   = i_s_axis_tdata;
    assign w_dig = (w_c >= CH_ZERO) && (w_c <= CH_NINE);
    assign w_dv  = w_dig ? w_c[3:0] : 4'd0;

    // per-character update
    always_comb begin
        n_str = r_str;
        if (!w_dig) begin
            n_str.digits = 1'b0;
        end
        if (w_dig && r_str.pos < MS_DIGITS_MAX) begin
            n_str.acc = (r_str.acc << 3) + (r_str.acc << 1) + OUT_W'(w_dv);
        end
        if (r_str.pos < ISO_LEN) begin
            case (r_str.pos)
                POS_DASH_Y, POS_DASH_M: begin
                    if (w_c != CH_DASH) n_str.iso_ok = 1'b0;
                end
                POS_SEP_T: begin
                    if (w_c != CH_T && w_c != CH_SPACE) n_str.iso_ok = 1'b0;
                end
                POS_COLON_H, POS_COLON_M: begin
                    if (w_c != CH_COLON) n_str.iso_ok = 1'b0;
                end
                default: begin
                    if (!w_dig) begin
                        n_str.iso_ok = 1'b0;
                    end else if (r_str.pos inside {[5'd0:5'd3]}) begin
                        n_str.year = YEAR_W'(r_str.year * 14'd10 + YEAR_W'(w_dv));
                    end else if (r_str.pos inside {[5'd5:5'd6]}) begin
                        n_str.mon = FLD_W'(r_str.mon * 7'd10 + FLD_W'(w_dv));
                    end else if (r_str.pos inside {[5'd8:5'd9]}) begin
                        n_str.day = FLD_W'(r_str.day * 7'd10 + FLD_W'(w_dv));
                    end else if (r_str.pos inside {[5'd11:5'd12]}) begin
                        n_str.hour = FLD_W'(r_str.hour * 7'd10 + FLD_W'(w_dv));
                    end else if (r_str.pos inside {[5'd14:5'd15]}) begin
                        n_str.minute = FLD_W'(r_str.minute * 7'd10 + FLD_W'(w_dv));
                    end else begin
                        n_str.sec = FLD_W'(r_str.sec * 7'd10 + FLD_W'(w_dv));
                    end
                end
            endcase
        end else if (r_str.pos == ISO_LEN) begin
            n_str.fopen = (w_c == CH_DOT);
        end else if (r_str.fopen) begin
            if (w_dig && r_str.fcnt != 2'd3) begin
                n_str.frac = FRAC_W'(r_str.frac * 10'd10 + FRAC_W'(w_dv));
                n_str.fcnt = r_str.fcnt + 2'd1;
            end else begin
                n_str.fopen = 1'b0;
            end
        end
        if (r_str.pos != POS_MAX) begin
            n_str.pos = r_str.pos + 5'd1;
        end
    end

    // stage 2: checks, year offset, century count
    assign w2_yy = r1_str.year - ((r1_str.mon <= 7'd2) ? 14'd1 : 14'd0);
    assign w2_t  = YOFF_W'(w2_yy - YEAR_BASE);

    always_comb begin
        w2_q = '0;
        for (int k = 1; k <= 14; k++) begin
            if (w2_t >= YOFF_W'(k * 100)) w2_q = Q_W'(k);
        end
    end

    always_comb begin
        w2_dmode = r1_zero || r1_str.digits;
        if (r1_zero) begin
            w2_dval = '0;
        end else if (r1_str.pos inside {[5'd12:5'd17]}) begin
            w2_dval = r1_str.acc;
        end else if (r1_str.pos inside {[5'd9:5'd11]}) begin
            w2_dval = OUT_W'(r1_str.acc[SEC_DIG_W-1:0] * 47'd1000);
        end else begin
            w2_dval = '0;
        end
        w2_bad = (r1_str.pos < ISO_LEN) || !r1_str.iso_ok
              || (r1_str.year < YEAR_MIN) || (r1_str.year > YEAR_MAX)
              || (r1_str.mon < 7'd1) || (r1_str.mon > 7'd12)
              || (r1_str.day < 7'd1) || (r1_str.day > 7'd31)
              || (r1_str.hour > 7'd23) || (r1_str.minute > 7'd59)
              || (r1_str.sec > 7'd60);
        case (r1_str.fcnt)
            2'd1:    w2_fms = FRAC_W'(r1_str.frac * 10'd100);
            2'd2:    w2_fms = FRAC_W'(r1_str.frac * 10'd10);
            default: w2_fms = r1_str.frac;
        endcase
    end

    // stage 3: days since 1970-01-01, seconds of the day
    assign w3_days = DAYS_W'(DAYS_W'(r2_t) * 19'd365) + DAYS_W'(r2_t >> 2)
                   + DAYS_W'(r2_q >> 2) + DAYS_W'(r2_moff) + DAYS_W'(r2_day)
                   - DAYS_W'(r2_q) - DAY_BIAS;
    assign w3_hms  = HMS_W'(HMS_W'(r2_hour) * 17'd3600 + HMS_W'(r2_min) * 17'd60
                   + HMS_W'(r2_sec));

    // stage 4
    assign w4_secs = SECS_W'(SECS_W'(r3_days) * 35'd86400) + SECS_W'(r3_hms);

    // stage 5
    assign w5_ms  = MS_W'(MS_W'(r4_secs) * 45'd1000) + MS_W'(r4_fms);
    assign w5_out = r4_dmode ? r4_dval
                  : (r4_bad || r4_secs > SECS_LIMIT) ? '0 : OUT_W'(w5_ms);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_str <= STR_RESET;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_str <= w_res ? STR_RESET : n_str;
            end
            if (w_rdy1) r_v1 <= w_in_acc && w_res;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r1_str  <= n_str;
            r1_zero <= !i_s_axis_tuser;
        end
        if (w_rdy2) begin
            r2_dmode <= w2_dmode;
            r2_bad   <= w2_bad;
            r2_dval  <= w2_dval;
            r2_fms   <= w2_fms;
            r2_t     <= w2_t;
            r2_q     <= w2_q;
            r2_moff  <= month_offset(r1_str.mon[3:0]);
            r2_day   <= r1_str.day;
            r2_hour  <= r1_str.hour;
            r2_min   <= r1_str.minute;
            r2_sec   <= r1_str.sec;
        end
        if (w_rdy3) begin
            r3_dmode <= r2_dmode;
            r3_bad   <= r2_bad;
            r3_dval  <= r2_dval;
            r3_fms   <= r2_fms;
            r3_days  <= w3_days;
            r3_hms   <= w3_hms;
        end
        if (w_rdy4) begin
            r4_dmode <= r3_dmode;
            r4_bad   <= r3_bad;
            r4_dval  <= r3_dval;
            r4_fms   <= r3_fms;
            r4_secs  <= w4_secs;
        end
        if (w_rdy5) begin
            r5_ms <= w5_out;
        end
    end

    assign o_m_axis_tvalid = r_v5;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, r5_ms};

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5))
        else $error("input stalled with a bubble in the pipeline");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_res) |=> (r_str.pos == '0 && r_str.digits && r_str.iso_ok))
        else $error("string state not cleared after end of request");

    a_end_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_res) |=> r_v1)
        else $error("end of string did not enter the pipeline");

    a_pos_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_res && r_str.pos != POS_MAX)
        |=> (r_str.pos == POS_W'($past(r_str.pos) + 5'd1)))
        else $error("character position did not advance");

endmodule

`default_nettype wire

@@ sim/timestamp_text_to_epoch_ms_top_tb.sv @@
module timestamp_text_to_epoch_ms_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ts2ep_pkg::*;

    localparam int ITEMS_PER_PHASE = 90;
    localparam int MS_DIGITS_MIN   = 12;
    localparam int SEC_DIGITS_MIN  = 9;
    localparam int SEC_DIGITS_MAX  = 11;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;   // [15:0] char_code
    logic                   i_s_axis_tuser = 1'b0; // [0] has_char
    logic                   i_s_axis_tlast = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;        // [56:0] epoch_ms

    typedef struct {
        string            text;
        logic [7:0]       hi;
        bit               open_end;
        bit               typed;
        logic [OUT_W-1:0] want;
    } t_dir_row;

    t_dir_row         dir_rows[$];
    logic [15:0]      text_q[$];
    logic [OUT_W-1:0] epoch_q[$];
    int               err_count = 0;
    int               rnd_items = 0;
    int               src_idle_pct = 30;
    int               snk_idle_pct = 48;

    // predictor state for the string in flight
    logic [POS_W-1:0]  txt_pos;
    bit                txt_digits;
    longint unsigned   txt_acc;
    bit                txt_iso_ok;
    logic [YEAR_W-1:0] txt_fld [6];
    logic [FRAC_W-1:0] txt_frac;
    logic [1:0]        txt_frac_cnt;
    bit                txt_frac_open;

    timestamp_text_to_epoch_ms_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10ns i_clk = ~i_clk;

    function automatic void clear_text();
        txt_pos = '0;
        txt_digits = 1'b1;
        txt_acc = 0;
        txt_iso_ok = 1'b1;
        foreach (txt_fld[k]) txt_fld[k] = '0;
        txt_frac = '0;
        txt_frac_cnt = '0;
        txt_frac_open = 1'b0;
    endfunction

    function automatic void add_char(input logic [15:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    // days since 1970-01-01, linear in the day of month
    function automatic longint unsigned day_count(input longint unsigned y,
                                                  input longint unsigned m,
                                                  input longint unsigned d);
        longint unsigned yy, era, yoe, mp, doy, doe;
        yy = y - ((m <= 2) ? 1 : 0);
        era = yy / 400;
        yoe = yy - era * 400;
        mp = (m + 9) % 12;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    task automatic advance_text(input logic [15:0] c, input bit has, input bit fin,
                                output bit produced, output logic [OUT_W-1:0] ms);
        bit              dig;
        logic [3:0]      dv;
        int              f;
        bit              ranges_ok;
        longint unsigned secs, cap_secs;
        logic [9:0]      frac_ms;
        produced = 1'b0;
        ms = '0;
        if (!has) begin
            produced = 1'b1;
            clear_text();
            return;
        end
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        dv = dig ? 4'(c - CH_ZERO) : 4'd0;
        if (!dig) txt_digits = 1'b0;
        if (dig && txt_pos < MS_DIGITS_MAX) txt_acc = txt_acc * 10 + dv;
        if (txt_pos < ISO_LEN) begin
            if (txt_pos == POS_DASH_Y || txt_pos == POS_DASH_M) begin
                if (c != CH_DASH) txt_iso_ok = 1'b0;
            end else if (txt_pos == POS_SEP_T) begin
                if (c != CH_T && c != CH_SPACE) txt_iso_ok = 1'b0;
            end else if (txt_pos == POS_COLON_H || txt_pos == POS_COLON_M) begin
                if (c != CH_COLON) txt_iso_ok = 1'b0;
            end else if (!dig) begin
                txt_iso_ok = 1'b0;
            end else begin
                f = txt_pos < POS_DASH_Y ? 0 : txt_pos < POS_DASH_M ? 1 :
                    txt_pos < POS_SEP_T ? 2 : txt_pos < POS_COLON_H ? 3 :
                    txt_pos < POS_COLON_M ? 4 : 5;
                txt_fld[f] = 14'(txt_fld[f] * 10 + dv);
            end
        end else if (txt_pos == ISO_LEN) begin
            txt_frac_open = (c == CH_DOT);
        end else if (txt_frac_open) begin
            if (dig && txt_frac_cnt < 3) begin
                txt_frac = 10'(txt_frac * 10 + dv);
                txt_frac_cnt = txt_frac_cnt + 2'd1;
            end else begin
                txt_frac_open = 1'b0;
            end
        end
        if (txt_pos < POS_MAX) txt_pos = txt_pos + 5'd1;
        if (!fin) return;

        produced = 1'b1;
        ranges_ok = txt_fld[0] >= YEAR_MIN && txt_fld[1] >= 1 && txt_fld[1] <= 12 &&
                    txt_fld[2] >= 1 && txt_fld[2] <= 31 && txt_fld[3] <= 23 &&
                    txt_fld[4] <= 59 && txt_fld[5] <= 60;
        if (txt_digits) begin
            if (txt_pos >= MS_DIGITS_MIN && txt_pos <= MS_DIGITS_MAX)
                ms = txt_acc[OUT_W-1:0];
            else if (txt_pos >= SEC_DIGITS_MIN && txt_pos <= SEC_DIGITS_MAX)
                ms = OUT_W'(txt_acc * 1000);
        end else if (txt_pos >= ISO_LEN && txt_iso_ok && ranges_ok) begin
            secs = day_count(txt_fld[0], txt_fld[1], txt_fld[2]) * 86400 +
                   txt_fld[3] * 3600 + txt_fld[4] * 60 + txt_fld[5];
            cap_secs = day_count(YEAR_MAX + 1, 1, 1) * 86400 - 1;
            frac_ms = (txt_frac_cnt == 2'd1) ? 10'(txt_frac * 100) :
                      (txt_frac_cnt == 2'd2) ? 10'(txt_frac * 10) : txt_frac;
            if (secs <= cap_secs) ms = OUT_W'(secs * 1000 + frac_ms);
        end
        clear_text();
    endtask

    task automatic send_item(input logic [15:0] c, input bit has, input bit fin,
                             input bit typed, input logic [OUT_W-1:0] typed_ms);
        bit               produced;
        logic [OUT_W-1:0] ms;
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tuser  <= has;
        i_s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        advance_text(c, has, fin, produced, ms);
        if (produced) epoch_q.insert(epoch_q.size(), typed ? typed_ms : ms);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (epoch_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] any_char();
        logic [15:0] seps [5];
        seps = '{CH_DASH, CH_COLON, CH_T, CH_SPACE, CH_DOT};
        case ($urandom_range(3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(32, 126));
            2: return CH_ZERO + 16'($urandom_range(9));
            default: return seps[$urandom_range(4)];
        endcase
    endfunction

    task automatic put_num(input int unsigned v, input int digits);
        int unsigned d;
        d = 1;
        repeat (digits - 1) d *= 10;
        repeat (digits) begin
            add_char(CH_ZERO + 16'((v / d) % 10));
            d /= 10;
        end
    endtask

    task automatic build_text(output bit open_end);
        int kind, yr, mo, dy, hr, mi, se, n;
        text_q.delete();
        open_end = 1'b0;
        kind = $urandom_range(99);
        if (kind < 20) begin
            // bare epoch number
            n = $urandom_range(1) ? $urandom_range(9, 17) : $urandom_range(1, 22);
            repeat (n) add_char(CH_ZERO + 16'($urandom_range(9)));
        end else if (kind < 30) begin
            repeat ($urandom_range(1, 31)) add_char(any_char());
        end else if (kind >= 37) begin
            if ($urandom_range(19) == 0) begin
                // right at the top of the year range
                yr = 3000; mo = 12; dy = 31; hr = 23; mi = 59;
                se = $urandom_range(58, 60);
            end else begin
                yr = ($urandom_range(9) == 0) ? $urandom_range(0, 9999) :
                                                $urandom_range(1970, 3000);
                mo = ($urandom_range(15) == 0) ? $urandom_range(0, 13) : $urandom_range(1, 12);
                dy = ($urandom_range(15) == 0) ? $urandom_range(0, 32) : $urandom_range(1, 31);
                hr = ($urandom_range(15) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 23);
                mi = ($urandom_range(15) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 59);
                se = ($urandom_range(15) == 0) ? $urandom_range(0, 61) : $urandom_range(0, 60);
            end
            put_num(yr, 4);
            add_char(CH_DASH);
            put_num(mo, 2);
            add_char(CH_DASH);
            put_num(dy, 2);
            add_char($urandom_range(1) ? CH_T : CH_SPACE);
            put_num(hr, 2);
            add_char(CH_COLON);
            put_num(mi, 2);
            add_char(CH_COLON);
            put_num(se, 2);
            case ($urandom_range(3))
                0: ;
                1: begin
                    add_char(CH_DOT);
                    repeat ($urandom_range(0, 4)) add_char(CH_ZERO + 16'($urandom_range(9)));
                end
                2: begin
                    add_char(CH_DOT);
                    repeat ($urandom_range(1, 3)) add_char(CH_ZERO + 16'($urandom_range(9)));
                    repeat ($urandom_range(0, 10)) add_char(any_char());
                end
                default: repeat ($urandom_range(1, 12)) add_char(any_char());
            endcase
            n = text_q.size();
            if (kind >= 90) begin
                // abandoned part way, closed by an empty request
                n = $urandom_range(1, n);
                while (text_q.size() > n) void'(text_q.pop_back());
                open_end = 1'b1;
            end else if ($urandom_range(9) == 0) begin
                text_q[$urandom_range(0, n - 1)] = any_char();
            end
        end
    endtask

    always @(posedge i_clk) begin : result_sink
        logic [OUT_W-1:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (epoch_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result %0d", o_m_axis_tdata);
            end else begin
                want = epoch_q.pop_front();
                if (o_m_axis_tdata !== {{(OUT_TDATA_W - OUT_W){1'b0}}, want}) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("epoch_ms mismatch: expected %0d got %0d", want,
                                 o_m_axis_tdata);
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    initial begin
        bit open_end;
        dir_rows = '{
            '{"",                            8'h00, 1'b0, 1'b1, 57'd0},
            '{"1700000000000",               8'h00, 1'b0, 1'b1, 57'd1700000000000},
            '{"1700000000",                  8'h00, 1'b0, 1'b1, 57'd1700000000000},
            '{"99999999999999999",           8'h00, 1'b0, 1'b1, 57'd99999999999999999},
            '{"999999999",                   8'h00, 1'b0, 1'b1, 57'd999999999000},
            '{"99999999999",                 8'h00, 1'b0, 1'b1, 57'd99999999999000},
            '{"12345678",                    8'h00, 1'b0, 1'b1, 57'd0},
            '{"123456789012345678",          8'h00, 1'b0, 1'b1, 57'd0},
            '{"1970-01-01T00:00:00",         8'h00, 1'b0, 1'b1, 57'd0},
            '{"1970-01-01 00:00:00.5",       8'h00, 1'b0, 1'b1, 57'd500},
            '{"1970-01-01T00:00:00.12",      8'h00, 1'b0, 1'b1, 57'd120},
            '{"1970-01-01T00:00:00.1234xyz", 8'h00, 1'b0, 1'b1, 57'd123},
            '{"2024-02-31T12:00:00",         8'h00, 1'b0, 1'b0, 57'd0},
            '{"2016-12-31T23:59:60.999",     8'h00, 1'b0, 1'b0, 57'd0},
            '{"3000-12-31T23:59:59.999",     8'h00, 1'b0, 1'b0, 57'd0},
            '{"3000-12-31T23:59:60",         8'h00, 1'b0, 1'b1, 57'd0},
            '{"1969-12-31T23:59:59",         8'h00, 1'b0, 1'b1, 57'd0},
            '{"2020-13-01T00:00:00",         8'h00, 1'b0, 1'b1, 57'd0},
            '{"2020-00-10T00:00:00",         8'h00, 1'b0, 1'b1, 57'd0},
            '{"2020-01-00T00:00:00",         8'h00, 1'b0, 1'b1, 57'd0},
            '{"2020-01-32T24:60:61",         8'h00, 1'b0, 1'b1, 57'd0},
            '{"2020-01-01X00:00:00",         8'h00, 1'b0, 1'b1, 57'd0},
            '{"2020/01-01T00:00:00",         8'h00, 1'b0, 1'b1, 57'd0},
            '{"2020-01-01T00:00",            8'h00, 1'b0, 1'b1, 57'd0},
            '{"2020-01-01T00:00:00",         8'hFF, 1'b0, 1'b1, 57'd0},
            '{"2023-06-15T08:3",             8'h00, 1'b1, 1'b0, 57'd0},
            '{"",                            8'h00, 1'b0, 1'b1, 57'd0},
            '{"2023-06-15T08:30:45Z plus trailing text", 8'h00, 1'b0, 1'b0, 57'd0}
        };
        clear_text();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].text.len() == 0) begin
                send_item(16'($urandom), 1'b0, 1'($urandom), dir_rows[r].typed,
                          dir_rows[r].want);
            end else begin
                for (int i = 0; i < dir_rows[r].text.len(); i++)
                    send_item({dir_rows[r].hi, dir_rows[r].text[i]}, 1'b1,
                              (i == dir_rows[r].text.len() - 1) && !dir_rows[r].open_end,
                              dir_rows[r].typed, dir_rows[r].want);
            end
        end
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 48 : 0;
            snk_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 30 : 0;
            while (rnd_items < (ph + 1) * ITEMS_PER_PHASE) begin
                build_text(open_end);
                foreach (text_q[i]) begin
                    send_item(text_q[i], 1'b1, (i == text_q.size() - 1) && !open_end,
                              1'b0, '0);
                    rnd_items++;
                end
                if (text_q.size() == 0 || open_end) begin
                    send_item(16'($urandom), 1'b0, 1'($urandom), 1'b0, '0);
                    rnd_items++;
                end
            end
            // hold requests back until every result is out
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0 && epoch_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
